// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the back end rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CMX_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CMX_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/cmx_pkg.sv -----
// types, constants and codes of the coaxial octo rotor mixer
package cmx_pkg;

   localparam int ROTORS = 8;
   localparam int ROTOR_W = 3;
   localparam int CMD_W = 32;
   localparam int FACT_W = 31;
   localparam int DRAG_W = 32;
   localparam int SQ_W = 32;
   localparam int SPEED_W = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WIDE_W = 64;
   localparam int OPND_W = 33;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int TERM_W = 62;
   localparam logic [TERM_W-1:0] TERM_CAP = {TERM_W{1'b1}};
   localparam int DIV_NUM_W = 90;
   localparam int DIV_STEPS = 45;
   localparam int DIV_CNT_W = 6;
   localparam int SHIFT_W = 5;
   localparam logic [SHIFT_W-1:0] SHIFT_A = 5'd24;
   localparam logic [SHIFT_W-1:0] SHIFT_B = 5'd25;

   localparam int SQRT_SHIFT = 14;
   localparam int SQV_W = SQ_W + SQRT_SHIFT;
   localparam int ROOT_W = SQV_W / 2;
   localparam int REM_W = ROOT_W + 2;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int SQRT_CNT_W = 5;

   localparam logic [FACT_W-1:0] THRUST_TOP_RST = 31'd40913000;
   localparam logic [FACT_W-1:0] THRUST_BOTTOM_RST = 31'd60615000;
   localparam logic signed [DRAG_W-1:0] DRAG_TOP_RST = -32'sd2425100;
   localparam logic signed [DRAG_W-1:0] DRAG_BOTTOM_RST = 32'sd918600;
   localparam logic [SQ_W-1:0] MAX_SPEED_SQ_RST = 32'd4000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRUST_TOP,
      CSR_THRUST_BOTTOM,
      CSR_DRAG_TOP,
      CSR_DRAG_BOTTOM,
      CSR_MAX_SPEED_SQ
   } cmx_csr_type;

   typedef struct packed {
      logic [FACT_W-1:0]        thrust_top;
      logic [FACT_W-1:0]        thrust_bottom;
      logic signed [DRAG_W-1:0] drag_top;
      logic signed [DRAG_W-1:0] drag_bottom;
      logic [SQ_W-1:0]          max_speed_sq;
   } cmx_cfg_type;

   // d, s, numerators of the drag term, and the four thrust products
   typedef struct packed {
      logic [WIDE_W-1:0]        d;
      logic [WIDE_W-1:0]        s;
      logic [WIDE_W-1:0]        nd_top;
      logic [WIDE_W-1:0]        nd_bot;
      logic [3:0][WIDE_W-1:0]   p;
   } cmx_job_type;

   typedef enum logic [3:0] {
      ST_D_A, ST_D_B, ST_S_A, ST_S_B, ST_NT_A, ST_NT_B, ST_NB_A, ST_NB_B,
      ST_P0, ST_P1, ST_P2, ST_P3
   } cmx_step_type;

   typedef enum logic [1:0] {
      F_IDLE, F_MUL, F_DRAIN, F_PUSH
   } cmx_front_state_type;

   typedef enum logic [2:0] {
      DV_A_TOP, DV_A_BOT, DV_B0, DV_B1, DV_B2, DV_B3
   } cmx_div_sel_type;

   typedef enum logic [2:0] {
      B_IDLE, B_DIV_GO, B_DIV_WAIT, B_SUM, B_ROOT, B_EMIT
   } cmx_back_state_type;

endpackage

// ----- hw/rtl/cmx_ifs.sv -----
// command and rotor result channel interfaces
interface cmx_req_if;
   import cmx_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [CMD_W-1:0] thrust_cmd;
   logic signed [CMD_W-1:0] roll_cmd;
   logic signed [CMD_W-1:0] pitch_cmd;
   logic signed [CMD_W-1:0] yaw_cmd;
   modport source (output valid, thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd, input ready);
   modport sink (input valid, thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd, output ready);
endinterface

interface cmx_rsp_if;
   import cmx_pkg::*;
   logic               valid;
   logic               ready;
   logic [ROTOR_W-1:0] rotor_index;
   logic [SQ_W-1:0]    speed_sq;
   logic [SPEED_W-1:0] speed;
   logic               last;
   modport source (output valid, rotor_index, speed_sq, speed, last, input ready);
   modport sink (input valid, rotor_index, speed_sq, speed, last, output ready);
endinterface

// ----- hw/rtl/cmx_front.sv -----
// front end: accepts a command and forms the products of the mix
module cmx_front (
   input  logic                 clock,
   input  logic                 reset,
   cmx_req_if.sink              req,
   input  cmx_pkg::cmx_cfg_type cfg,
   output logic                 push_valid,
   input  logic                 push_ready,
   output cmx_pkg::cmx_job_type push_data
);
   import cmx_pkg::*;

   cmx_front_state_type     state_ff, state_in;
   cmx_step_type            step_ff, pstep_ff;
   logic                    pvld_ff;
   logic signed [CMD_W-1:0] u1_ff, u2_ff, u3_ff, u4_ff;
   logic [WIDE_W-1:0]       prod_ff;
   cmx_job_type             job_ff;
   logic signed [OPND_W-1:0] opa, opb;
   logic signed [2*OPND_W-1:0] prod;
   logic signed [OPND_W-1:0] t_top, t_bot, d_top, d_bot, u1, u2, u3, u4;

   assign t_top = $signed({2'b00, cfg.thrust_top});
   assign t_bot = $signed({2'b00, cfg.thrust_bottom});
   assign d_top = OPND_W'(cfg.drag_top);
   assign d_bot = OPND_W'(cfg.drag_bottom);
   assign u1 = OPND_W'(u1_ff);
   assign u2 = OPND_W'(u2_ff);
   assign u3 = OPND_W'(u3_ff);
   assign u4 = OPND_W'(u4_ff);

   always_comb begin
      case (step_ff)
         ST_D_A:  begin opa = t_top; opb = d_bot; end
         ST_D_B:  begin opa = t_bot; opb = d_top; end
         ST_S_A:  begin opa = t_top; opb = t_top; end
         ST_S_B:  begin opa = t_bot; opb = t_bot; end
         ST_NT_A: begin opa = u1;    opb = d_bot; end
         ST_NT_B: begin opa = u4;    opb = t_bot; end
         ST_NB_A: begin opa = u4;    opb = t_top; end
         ST_NB_B: begin opa = u1;    opb = d_top; end
         ST_P0:   begin opa = u3;    opb = t_top; end
         ST_P1:   begin opa = u2;    opb = t_top; end
         ST_P2:   begin opa = u3;    opb = t_bot; end
         ST_P3:   begin opa = u2;    opb = t_bot; end
         default: begin opa = '0;    opb = '0;    end
      endcase
   end

   assign prod = opa * opb;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (req.valid) state_in = F_MUL;
         F_MUL:   if (step_ff == ST_P3) state_in = F_DRAIN;
         F_DRAIN: state_in = F_PUSH;
         F_PUSH:  if (push_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req.ready  = (state_ff == F_IDLE);
      push_valid = (state_ff == F_PUSH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pvld_ff  <= (state_ff == F_MUL);
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         u1_ff   <= req.thrust_cmd;
         u2_ff   <= req.roll_cmd;
         u3_ff   <= req.pitch_cmd;
         u4_ff   <= req.yaw_cmd;
         step_ff <= ST_D_A;
      end else if (state_ff == F_MUL) begin
         step_ff <= cmx_step_type'(step_ff + 4'd1);
      end
      pstep_ff <= step_ff;
      prod_ff  <= prod[WIDE_W-1:0];
      if (pvld_ff) begin
         case (pstep_ff)
            ST_D_A:  job_ff.d      <= prod_ff;
            ST_D_B:  job_ff.d      <= job_ff.d - prod_ff;
            ST_S_A:  job_ff.s      <= prod_ff;
            ST_S_B:  job_ff.s      <= job_ff.s + prod_ff;
            ST_NT_A: job_ff.nd_top <= prod_ff;
            ST_NT_B: job_ff.nd_top <= job_ff.nd_top - prod_ff;
            ST_NB_A: job_ff.nd_bot <= prod_ff;
            ST_NB_B: job_ff.nd_bot <= job_ff.nd_bot - prod_ff;
            ST_P0:   job_ff.p[0]   <= prod_ff;
            ST_P1:   job_ff.p[1]   <= prod_ff;
            ST_P2:   job_ff.p[2]   <= prod_ff;
            ST_P3:   job_ff.p[3]   <= prod_ff;
            default: job_ff.d      <= job_ff.d;
         endcase
      end
   end

   assign push_data = job_ff;

endmodule

// ----- hw/rtl/cmx_queue.sv -----
// small queue between front and back
module cmx_queue #(
   parameter int DEPTH = cmx_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  cmx_pkg::cmx_job_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output cmx_pkg::cmx_job_type pop_data
);
   import cmx_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmx_job_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, rd_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_FULL);
   assign pop_valid  = (cnt_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
         if (do_pop) rd_ff <= (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// ----- hw/rtl/cmx_div.sv -----
// shared divider: saturated floor(num * 2^shift / den), two quotient bits a cycle
module cmx_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [cmx_pkg::WIDE_W-1:0]            num,
   input  logic [cmx_pkg::WIDE_W-1:0]            den,
   input  logic [cmx_pkg::SHIFT_W-1:0]           shift,
   output logic                                  busy,
   output logic                                  done,
   output logic [cmx_pkg::TERM_W-1:0]            quo
);
   import cmx_pkg::*;

   logic                 busy_ff, done_ff, ovf_ff;
   logic [DIV_NUM_W-1:0] n_ff;
   logic [WIDE_W-1:0]    r_ff, d_ff;
   logic [TERM_W-1:0]    q_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [WIDE_W:0]      r1, r2;
   logic [WIDE_W-1:0]    r1_in, r2_in;
   logic                 ge1, ge2;

   always_comb begin
      r1    = {r_ff, n_ff[DIV_NUM_W-1]};
      ge1   = (r1 >= {1'b0, d_ff});
      r1_in = ge1 ? WIDE_W'(r1 - {1'b0, d_ff}) : r1[WIDE_W-1:0];
      r2    = {r1_in, n_ff[DIV_NUM_W-2]};
      ge2   = (r2 >= {1'b0, d_ff});
      r2_in = ge2 ? WIDE_W'(r2 - {1'b0, d_ff}) : r2[WIDE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff   <= DIV_NUM_W'(num) << shift;
         d_ff   <= den;
         r_ff   <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         n_ff   <= {n_ff[DIV_NUM_W-3:0], 2'b00};
         r_ff   <= r2_in;
         q_ff   <= {q_ff[TERM_W-3:0], ge1, ge2};
         ovf_ff <= ovf_ff | q_ff[TERM_W-1] | q_ff[TERM_W-2];
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = ovf_ff ? TERM_CAP : q_ff;

endmodule

// ----- hw/rtl/cmx_back.sv -----
// back end: divides, mixes, clamps and takes square roots per rotor
module cmx_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  cmx_pkg::cmx_job_type          pop_data,
   input  logic [cmx_pkg::SQ_W-1:0]      max_speed_sq,
   output logic                          div_start,
   output logic [cmx_pkg::WIDE_W-1:0]    div_num,
   output logic [cmx_pkg::WIDE_W-1:0]    div_den,
   output logic [cmx_pkg::SHIFT_W-1:0]   div_shift,
   input  logic                          div_busy,
   input  logic                          div_done,
   input  logic [cmx_pkg::TERM_W-1:0]    div_quo,
   cmx_rsp_if.source                     rsp
);
   import cmx_pkg::*;

   `include "assert_macros.svh"

   cmx_back_state_type       state_ff, state_in;
   cmx_job_type              job_ff;
   cmx_div_sel_type          sel_ff;
   logic signed [WIDE_W-1:0] a_top_ff, a_bot_ff;
   logic signed [WIDE_W-1:0] b_ff [4];
   logic [ROTOR_W-1:0]       rotor_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic [SQV_W-1:0]         val_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic [SQRT_CNT_W-1:0]    cnt_ff;
   logic                     out_valid_ff, out_last_ff;
   logic [ROTOR_W-1:0]       out_idx_ff;
   logic [SQ_W-1:0]          out_sq_ff;
   logic [SPEED_W-1:0]       out_speed_ff;
   logic                     load_out, out_free;

   logic [WIDE_W-1:0]        snum, sden;
   logic                     neg, den_zero;
   logic signed [WIDE_W-1:0] term, qmag;
   logic [2:0]               bsel_w;
   logic signed [WIDE_W-1:0] a_val, b_val, b_mix, sum;
   logic [SQ_W-1:0]          clamp;
   logic [REM_W+1:0]         rem_sh, trial;

   always_comb begin
      case (sel_ff)
         DV_A_TOP: begin snum = job_ff.nd_top; sden = job_ff.d; div_shift = SHIFT_A; end
         DV_A_BOT: begin snum = job_ff.nd_bot; sden = job_ff.d; div_shift = SHIFT_A; end
         DV_B0:    begin snum = job_ff.p[0];   sden = job_ff.s; div_shift = SHIFT_B; end
         DV_B1:    begin snum = job_ff.p[1];   sden = job_ff.s; div_shift = SHIFT_B; end
         DV_B2:    begin snum = job_ff.p[2];   sden = job_ff.s; div_shift = SHIFT_B; end
         DV_B3:    begin snum = job_ff.p[3];   sden = job_ff.s; div_shift = SHIFT_B; end
         default:  begin snum = '0;            sden = '0;       div_shift = SHIFT_A; end
      endcase
      div_num  = snum[WIDE_W-1] ? WIDE_W'(-snum) : snum;
      div_den  = sden[WIDE_W-1] ? WIDE_W'(-sden) : sden;
      neg      = snum[WIDE_W-1] ^ sden[WIDE_W-1];
      den_zero = (sden == '0);
      qmag     = $signed({{(WIDE_W-TERM_W){1'b0}}, div_quo});
      term     = den_zero ? '0 : (neg ? -qmag : qmag);
      bsel_w   = sel_ff - DV_B0;
   end

   // rotor mix: top layer uses rotor bit 2 clear, pitch on even positions
   always_comb begin
      a_val = rotor_ff[2] ? a_bot_ff : a_top_ff;
      b_val = b_ff[{rotor_ff[2], rotor_ff[0]}];
      b_mix = (rotor_ff[0] ^ rotor_ff[1]) ? -b_val : b_val;
      sum   = a_val + b_mix;
      if (sum[WIDE_W-1]) clamp = '0;
      else if (sum > $signed({{(WIDE_W-SQ_W){1'b0}}, max_speed_sq})) clamp = max_speed_sq;
      else clamp = sum[SQ_W-1:0];
      rem_sh = {rem_ff, val_ff[SQV_W-1 -: 2]};
      trial  = (REM_W+2)'({root_ff, 2'b01});
   end

   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:     if (pop_valid) state_in = B_DIV_GO;
         B_DIV_GO:   state_in = B_DIV_WAIT;
         B_DIV_WAIT: if (div_done) state_in = (sel_ff == DV_B3) ? B_SUM : B_DIV_GO;
         B_SUM:      state_in = B_ROOT;
         B_ROOT:     if (cnt_ff == SQRT_CNT_W'(SQRT_STEPS - 1)) state_in = B_EMIT;
         B_EMIT: begin
            if (out_free) state_in = (rotor_ff == ROTOR_W'(ROTORS - 1)) ? B_IDLE : B_SUM;
         end
         default:    state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = (state_ff == B_IDLE);
      div_start = (state_ff == B_DIV_GO);
      load_out  = (state_ff == B_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               job_ff   <= pop_data;
               sel_ff   <= DV_A_TOP;
               rotor_ff <= '0;
            end
         end
         B_DIV_WAIT: begin
            if (div_done) begin
               if (sel_ff == DV_A_TOP) a_top_ff <= term;
               else if (sel_ff == DV_A_BOT) a_bot_ff <= term;
               else b_ff[bsel_w[1:0]] <= term;
               if (sel_ff != DV_B3) sel_ff <= cmx_div_sel_type'(sel_ff + 3'd1);
            end
         end
         B_SUM: begin
            sq_ff   <= clamp;
            val_ff  <= {clamp, {SQRT_SHIFT{1'b0}}};
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         B_ROOT: begin
            val_ff <= {val_ff[SQV_W-3:0], 2'b00};
            cnt_ff <= cnt_ff + 1'b1;
            if (rem_sh >= trial) begin
               rem_ff  <= REM_W'(rem_sh - trial);
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh[REM_W-1:0];
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         B_EMIT: begin
            if (load_out) rotor_ff <= rotor_ff + 1'b1;
         end
         default: begin
            sel_ff <= sel_ff;
         end
      endcase
      if (load_out) begin
         out_idx_ff   <= rotor_ff;
         out_sq_ff    <= sq_ff;
         out_speed_ff <= SPEED_W'(root_ff);
         out_last_ff  <= (rotor_ff == ROTOR_W'(ROTORS - 1));
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.rotor_index = out_idx_ff;
   assign rsp.speed_sq    = out_sq_ff;
   assign rsp.speed       = out_speed_ff;
   assign rsp.last        = out_last_ff;

   `CMX_ASSERT_IMPLY(a_last_rotor, clock, reset, out_valid_ff && out_last_ff, out_idx_ff == ROTOR_W'(ROTORS - 1))
   `CMX_ASSERT_IMPLY(a_sq_clamped, clock, reset, out_valid_ff, out_sq_ff <= max_speed_sq)
   `CMX_ASSERT_NEXT(a_div_started, clock, reset, div_start, div_busy)

endmodule

// ----- hw/rtl/coaxial_octo_rotor_mixer_core.sv -----
// coaxial eight-rotor mixer top level: config registers, front, queue, divider, back
// each command takes six passes through the shared two-bit-per-cycle divider
//   and eight 23-step square roots in the back, one per rotor result
// the front product pass overlaps the back through the queue, so a new command
//   can be accepted while the back still works on earlier ones
// reset: synchronous, active high; clears control state and loads register defaults
module coaxial_octo_rotor_mixer_core #(
   parameter int QUEUE_DEPTH = cmx_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [cmx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cmx_pkg::CSR_DATA_W-1:0]    csr_wdata,
   cmx_req_if.sink                           req_chan,
   cmx_rsp_if.source                         rsp_chan
);
   import cmx_pkg::*;

   cmx_cfg_type          cfg_ff;
   logic                 push_valid, push_ready, pop_valid, pop_ready;
   cmx_job_type          push_data, pop_data;
   logic                 div_start, div_busy, div_done;
   logic [WIDE_W-1:0]    div_num, div_den;
   logic [SHIFT_W-1:0]   div_shift;
   logic [TERM_W-1:0]    div_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thrust_top    <= THRUST_TOP_RST;
         cfg_ff.thrust_bottom <= THRUST_BOTTOM_RST;
         cfg_ff.drag_top      <= DRAG_TOP_RST;
         cfg_ff.drag_bottom   <= DRAG_BOTTOM_RST;
         cfg_ff.max_speed_sq  <= MAX_SPEED_SQ_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRUST_TOP:    cfg_ff.thrust_top    <= csr_wdata[FACT_W-1:0];
            CSR_THRUST_BOTTOM: cfg_ff.thrust_bottom <= csr_wdata[FACT_W-1:0];
            CSR_DRAG_TOP:      cfg_ff.drag_top      <= $signed(csr_wdata[DRAG_W-1:0]);
            CSR_DRAG_BOTTOM:   cfg_ff.drag_bottom   <= $signed(csr_wdata[DRAG_W-1:0]);
            CSR_MAX_SPEED_SQ:  cfg_ff.max_speed_sq  <= csr_wdata[SQ_W-1:0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   cmx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   cmx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cmx_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .shift (div_shift),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   cmx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_data     (pop_data),
      .max_speed_sq (cfg_ff.max_speed_sq),
      .div_start    (div_start),
      .div_num      (div_num),
      .div_den      (div_den),
      .div_shift    (div_shift),
      .div_busy     (div_busy),
      .div_done     (div_done),
      .div_quo      (div_quo),
      .rsp          (rsp_chan)
   );

endmodule
